### design/ffra_pkg.sv
// Shared types and constants for the first-fit region allocator.
// No dependencies; used by the allocator and the gap unit.
package ffra_pkg;

    localparam int DEF_MAX_BLOCKS = 64;
    localparam int DEF_ADDR_BITS  = 20;

    localparam int FIELD_W   = 20;          // size / address / count fields
    localparam int HDR_W     = 8;           // header register
    localparam int CUR_W     = FIELD_W + 1; // walk cursor: start + length
    localparam int CHG_W     = FIELD_W + 1; // request + header
    localparam int CFG_IDX_W = 2;

    localparam logic [FIELD_W-1:0] POOL_RESET = FIELD_W'(1000000);
    localparam logic [HDR_W-1:0]   HDR_RESET  = HDR_W'(32);

    localparam logic [CFG_IDX_W-1:0] REG_POOL   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEADER = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK         = 2'd0,
        STS_NO_SPACE   = 2'd1,
        STS_NOT_ALLOC  = 2'd2,
        STS_TABLE_FULL = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_INSERT,
        S_SHIFT_DN
    } t_state;

    typedef struct packed {
        logic hit;   // gap found (allocate) or address match (free / query)
        logic fits;  // cursor + charge + header stays below the pool end
    } t_unit_flags;

endpackage

### design/first_fit_region_allocator.sv
// First-fit region allocator: sorted block table in RAM, walked one entry per
// cycle by a shared compare unit. Table-full, no-funds, address-zero and
// empty-table cases answer straight from idle; else the walk scans entries,
// shifts entries up (allocate) or down (free), and writes a new entry on allocate.
// One request at a time; the next is taken while o_done is high and busy low.
// Receiver cannot stall. Sync active-low reset: empty table, default pool and header.
module first_fit_region_allocator #(
    parameter int MAX_BLOCKS = ffra_pkg::DEF_MAX_BLOCKS,
    parameter int ADDR_BITS  = ffra_pkg::DEF_ADDR_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_operation,
    input  logic [ffra_pkg::FIELD_W-1:0]   i_req_size,
    input  logic [ffra_pkg::FIELD_W-1:0]   i_address,
    output logic                           o_done,
    output logic [1:0]                     o_status,
    output logic [ffra_pkg::FIELD_W-1:0]   o_block_addr,
    output logic [ffra_pkg::FIELD_W-1:0]   o_block_size,
    output logic [ffra_pkg::FIELD_W-1:0]   o_free_count,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ffra_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ffra_pkg::FIELD_W-1:0]   i_cfg_data
);

    localparam int FW = ffra_pkg::FIELD_W;
    localparam int SW = (ADDR_BITS < FW) ? ADDR_BITS : FW;
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int EW = SW + FW;
    localparam int CHW = ffra_pkg::CHG_W;
    localparam int CUW = ffra_pkg::CUR_W;

    ffra_pkg::t_state r_state, n_state;
    ffra_pkg::t_op    r_op, n_op;
    logic [FW-1:0]    r_req, n_req;
    logic [SW-1:0]    r_addr, n_addr;
    logic [CHW-1:0]   r_charge, n_charge;
    logic [CUW-1:0]   r_cursor, n_cursor;
    logic [CW-1:0]    r_pos, n_pos;
    logic [CW-1:0]    r_idx, n_idx;
    logic [FW-1:0]    r_len, n_len;
    logic [CW-1:0]    r_count, n_count;
    logic [FW-1:0]    r_free, n_free;
    logic [FW-1:0]    r_pool, n_pool;
    logic [ffra_pkg::HDR_W-1:0] r_header, n_header;

    logic             r_done, n_done;
    ffra_pkg::t_status r_status, n_status;
    logic [FW-1:0]    r_o_addr, n_o_addr;
    logic [FW-1:0]    r_o_size, n_o_size;
    logic [FW-1:0]    r_o_free, n_o_free;

    // RAM port
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;
    logic [SW-1:0] rd_start;
    logic [FW-1:0] rd_len;

    // decode
    ffra_pkg::t_op         in_op;
    logic [SW-1:0]         in_addr;
    logic                  addr_zero;
    logic [CHW-1:0]        charge_in;
    logic                  acc_start;
    logic                  cfg_wr;
    logic                  tbl_full;
    logic                  tbl_empty;
    logic                  no_funds;
    logic                  scan_end;
    logic                  last_up;
    logic                  last_dn;
    logic                  shift_dn;
    logic                  is_alloc;
    logic [FW+1:0]         credit;
    logic [FW-1:0]         credit_sat;
    logic [SW-1:0]         new_start;
    ffra_pkg::t_unit_flags uflags;
    logic [CUW-1:0]        next_cursor;

    ffra_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_start = ram_rdata[EW-1:FW];
    assign rd_len   = ram_rdata[FW-1:0];

    ffra_gap_unit #(
        .SW (SW)
    ) u_unit (
        .i_find        (!is_alloc),
        .i_start       (rd_start),
        .i_len         (rd_len),
        .i_addr        (r_addr),
        .i_cursor      (r_cursor),
        .i_charge      (r_charge),
        .i_header      (r_header),
        .i_pool        (r_pool),
        .o_flags       (uflags),
        .o_next_cursor (next_cursor)
    );

    assign in_op     = ffra_pkg::t_op'(i_operation);
    assign in_addr   = i_address[SW-1:0];
    assign addr_zero = (in_addr == '0);
    assign charge_in = CHW'(i_req_size) + CHW'(r_header);
    assign acc_start = start && (r_state == ffra_pkg::S_IDLE);
    assign cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign tbl_full  = (r_count == CW'(MAX_BLOCKS));
    assign tbl_empty = (r_count == '0);
    assign no_funds  = CHW'(r_free) < charge_in;
    assign scan_end  = (r_pos == r_count);
    assign last_up   = (r_idx == r_pos);
    assign last_dn   = (r_idx == (r_count - CW'(1)));
    assign shift_dn  = ((r_pos + CW'(1)) < r_count);
    assign is_alloc  = (r_op == ffra_pkg::OP_ALLOC);
    assign new_start = SW'(r_cursor + CUW'(r_header));

    assign credit     = (FW+2)'(r_free) + (FW+2)'(rd_len) + (FW+2)'(r_header);
    assign credit_sat = (credit[FW+1:FW] != '0) ? '1 : credit[FW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ffra_pkg::S_IDLE: begin
                if (acc_start) begin
                    case (in_op)
                        ffra_pkg::OP_ALLOC: begin
                            if (!tbl_full && !no_funds && !tbl_empty) begin
                                n_state = ffra_pkg::S_SCAN;
                            end
                        end
                        ffra_pkg::OP_FREE, ffra_pkg::OP_QUERY: begin
                            if (!addr_zero && !tbl_empty) begin
                                n_state = ffra_pkg::S_SCAN;
                            end
                        end
                        default: n_state = ffra_pkg::S_IDLE;
                    endcase
                end
            end
            ffra_pkg::S_SCAN: begin
                if (is_alloc) begin
                    if (scan_end) begin
                        n_state = uflags.fits ? ffra_pkg::S_INSERT : ffra_pkg::S_IDLE;
                    end else if (uflags.hit) begin
                        n_state = uflags.fits ? ffra_pkg::S_SHIFT_UP : ffra_pkg::S_IDLE;
                    end
                end else begin
                    if (scan_end) begin
                        n_state = ffra_pkg::S_IDLE;
                    end else if (uflags.hit) begin
                        n_state = (r_op == ffra_pkg::OP_FREE && shift_dn) ?
                                  ffra_pkg::S_SHIFT_DN : ffra_pkg::S_IDLE;
                    end
                end
            end
            ffra_pkg::S_SHIFT_UP: begin
                if (last_up) begin
                    n_state = ffra_pkg::S_INSERT;
                end
            end
            ffra_pkg::S_INSERT: n_state = ffra_pkg::S_IDLE;
            ffra_pkg::S_SHIFT_DN: begin
                if (last_dn) begin
                    n_state = ffra_pkg::S_IDLE;
                end
            end
            default: n_state = ffra_pkg::S_IDLE;
        endcase
    end

    // datapath, RAM control and results
    always_comb begin
        n_op     = r_op;
        n_req    = r_req;
        n_addr   = r_addr;
        n_charge = r_charge;
        n_cursor = r_cursor;
        n_pos    = r_pos;
        n_idx    = r_idx;
        n_len    = r_len;
        n_count  = r_count;
        n_free   = r_free;
        n_pool   = r_pool;
        n_header = r_header;
        n_done   = 1'b0;
        n_status = ffra_pkg::STS_OK;
        n_o_addr = '0;
        n_o_size = '0;
        n_o_free = r_free;
        ram_we    = 1'b0;
        ram_waddr = IW'(r_pos);
        ram_wdata = {new_start, r_req};
        ram_raddr = IW'(r_pos + CW'(1));

        case (r_state)
            ffra_pkg::S_IDLE: begin
                ram_raddr = '0;
                if (acc_start) begin
                    n_op     = in_op;
                    n_req    = i_req_size;
                    n_addr   = in_addr;
                    n_charge = charge_in;
                    n_cursor = '0;
                    n_pos    = '0;
                    n_done   = 1'b1;
                    case (in_op)
                        ffra_pkg::OP_ALLOC: begin
                            if (tbl_full) begin
                                n_status = ffra_pkg::STS_TABLE_FULL;
                            end else if (no_funds) begin
                                n_status = ffra_pkg::STS_NO_SPACE;
                            end else if (tbl_empty) begin
                                // empty pool: block goes right after one header
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                ram_wdata = {SW'(r_header), i_req_size};
                                n_count   = CW'(1);
                                n_free    = r_free - FW'(charge_in);
                                n_o_addr  = FW'(SW'(r_header));
                                n_o_free  = n_free;
                            end else begin
                                n_done = 1'b0;
                            end
                        end
                        ffra_pkg::OP_FREE, ffra_pkg::OP_QUERY: begin
                            if (addr_zero) begin
                                // address zero names the pool head
                                if (in_op == ffra_pkg::OP_QUERY) begin
                                    n_o_size = r_free;
                                end
                            end else if (tbl_empty) begin
                                n_status = ffra_pkg::STS_NOT_ALLOC;
                            end else begin
                                n_done = 1'b0;
                            end
                        end
                        default: n_status = ffra_pkg::STS_OK;
                    endcase
                end
            end
            ffra_pkg::S_SCAN: begin
                if (is_alloc) begin
                    if (scan_end || uflags.hit) begin
                        if (!uflags.fits) begin
                            n_done   = 1'b1;
                            n_status = ffra_pkg::STS_NO_SPACE;
                        end else if (!scan_end) begin
                            n_idx     = r_count - CW'(1);
                            ram_raddr = IW'(r_count - CW'(1));
                        end
                    end else begin
                        n_cursor = next_cursor;
                        n_pos    = r_pos + CW'(1);
                    end
                end else begin
                    if (scan_end) begin
                        n_done   = 1'b1;
                        n_status = ffra_pkg::STS_NOT_ALLOC;
                    end else if (uflags.hit) begin
                        n_len = rd_len;
                        if (r_op == ffra_pkg::OP_QUERY) begin
                            n_done   = 1'b1;
                            n_o_size = rd_len;
                        end else begin
                            n_free = credit_sat;
                            if (shift_dn) begin
                                n_idx = r_pos + CW'(1);
                            end else begin
                                n_count  = r_count - CW'(1);
                                n_done   = 1'b1;
                                n_o_size = rd_len;
                                n_o_free = credit_sat;
                            end
                        end
                    end else begin
                        n_pos = r_pos + CW'(1);
                    end
                end
            end
            ffra_pkg::S_SHIFT_UP: begin
                // move entry idx to idx+1, top entry first
                ram_we    = 1'b1;
                ram_waddr = IW'(r_idx + CW'(1));
                ram_wdata = ram_rdata;
                ram_raddr = IW'(r_idx - CW'(1));
                if (!last_up) begin
                    n_idx = r_idx - CW'(1);
                end
            end
            ffra_pkg::S_INSERT: begin
                ram_we   = 1'b1;
                n_count  = r_count + CW'(1);
                n_free   = r_free - FW'(r_charge);
                n_done   = 1'b1;
                n_o_addr = FW'(new_start);
                n_o_free = n_free;
            end
            ffra_pkg::S_SHIFT_DN: begin
                // move entry idx to idx-1, lowest entry first
                ram_we    = 1'b1;
                ram_waddr = IW'(r_idx - CW'(1));
                ram_wdata = ram_rdata;
                ram_raddr = IW'(r_idx + CW'(1));
                if (last_dn) begin
                    n_count  = r_count - CW'(1);
                    n_done   = 1'b1;
                    n_o_size = r_len;
                    n_o_free = r_free;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            default: n_done = 1'b0;
        endcase

        if (cfg_wr) begin
            case (i_cfg_index)
                ffra_pkg::REG_POOL: begin
                    n_pool  = i_cfg_data;
                    n_count = '0;
                    n_free  = i_cfg_data;
                end
                ffra_pkg::REG_HEADER: n_header = i_cfg_data[ffra_pkg::HDR_W-1:0];
                default: n_header = r_header;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ffra_pkg::S_IDLE;
            r_count  <= '0;
            r_free   <= ffra_pkg::POOL_RESET;
            r_pool   <= ffra_pkg::POOL_RESET;
            r_header <= ffra_pkg::HDR_RESET;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_free   <= n_free;
            r_pool   <= n_pool;
            r_header <= n_header;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_req    <= n_req;
        r_addr   <= n_addr;
        r_charge <= n_charge;
        r_cursor <= n_cursor;
        r_pos    <= n_pos;
        r_idx    <= n_idx;
        r_len    <= n_len;
        r_status <= n_status;
        r_o_addr <= n_o_addr;
        r_o_size <= n_o_size;
        r_o_free <= n_o_free;
    end

    assign busy         = (r_state != ffra_pkg::S_IDLE);
    assign o_cfg_ready  = (r_state == ffra_pkg::S_IDLE);
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_block_addr = r_o_addr;
    assign o_block_size = r_o_size;
    assign o_free_count = r_o_free;

    // a result only follows a request taken or a walk in progress
    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start || busy))
        else $error("result strobe without a request in flight");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BLOCKS))
        else $error("block count above table depth");

    a_shift_up_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffra_pkg::S_SHIFT_UP) |-> (r_idx >= r_pos) && (r_idx < r_count))
        else $error("insert shift index out of range");

    a_shift_dn_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffra_pkg::S_SHIFT_DN) |-> (r_idx > r_pos) && (r_idx < r_count))
        else $error("remove shift index out of range");

endmodule

### design/ffra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffra_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/ffra_gap_unit.sv
// Shared per-entry compare unit: gap test, address match, end-of-pool fit
// and cursor advance. Depends on ffra_pkg.
module ffra_gap_unit #(
    parameter int SW = 20
) (
    input  logic                         i_find,
    input  logic [SW-1:0]                i_start,
    input  logic [ffra_pkg::FIELD_W-1:0] i_len,
    input  logic [SW-1:0]                i_addr,
    input  logic [ffra_pkg::CUR_W-1:0]   i_cursor,
    input  logic [ffra_pkg::CHG_W-1:0]   i_charge,
    input  logic [ffra_pkg::HDR_W-1:0]   i_header,
    input  logic [ffra_pkg::FIELD_W-1:0] i_pool,
    output ffra_pkg::t_unit_flags        o_flags,
    output logic [ffra_pkg::CUR_W-1:0]   o_next_cursor
);

    localparam int DW = ffra_pkg::CUR_W + 1;
    localparam int FW = ffra_pkg::CUR_W + 2;

    logic [DW-1:0] st_x;
    logic [DW-1:0] cur_x;
    logic [DW-1:0] need;
    logic          gap_hit;

    assign st_x  = DW'(i_start);
    assign cur_x = DW'(i_cursor);
    // a gap must exceed the charge plus one more header
    assign need  = DW'(i_charge) + DW'(i_header);

    assign gap_hit = (st_x >= cur_x) && ((st_x - cur_x) > need);

    assign o_flags.hit  = i_find ? (i_start == i_addr) : gap_hit;
    assign o_flags.fits = (FW'(i_cursor) + FW'(need)) < FW'(i_pool);

    assign o_next_cursor = ffra_pkg::CUR_W'(i_start) + ffra_pkg::CUR_W'(i_len);

endmodule
